// ===== hw/rtl/rhcc_pkg.sv =====
// Shared types and constants of the RGB hue color classifier.
// Depends on nothing; used by rgb_hue_color_classifier.
package rhcc_pkg;

  localparam int PIX_W     = 8;
  localparam int HUE_OUT_W = 15;
  localparam int CLASS_W   = 2;

  localparam int DEG_60    = 60;
  localparam int DEG_120   = 120;
  localparam int DEG_240   = 240;
  localparam int DEG_360   = 360;
  localparam int DEG_30    = 30;
  localparam int DEG_75    = 75;
  localparam int DEG_135   = 135;
  localparam int DEG_345   = 345;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE   = 2'd0,
    CLS_RED    = 2'd1,
    CLS_YELLOW = 2'd2,
    CLS_GREEN  = 2'd3
  } color_class_e;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

endpackage

// ===== hw/rtl/rgb_hue_color_classifier.sv =====
// Top level: RGB pixel to HSV hue and coarse color class, fully pipelined.
// Depends on rhcc_pkg (types, degree constants).
//
//   channel | direction | signals
//   --------+-----------+----------------------------------------------------------------
//   pixel   | in        | in_valid_i, in_ready_o, red_i, green_i, blue_i
//   result  | out       | out_valid_o, out_ready_i, hue_angle_o, color_class_o, is_gray_o
//
// One transaction in and one out per cycle while out_ready_i is held high. QW =
// clog2(60 * 2^FRAC_BITS + 1) is the number of restoring divider stages; the
// stages are analyze, multiply, QW divide steps, hue, class.
// Every stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles collapse during an output stall.
// Reset clears the valid bits only.
module rgb_hue_color_classifier #(
  parameter int FRAC_BITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rhcc_pkg::PIX_W-1:0]          red_i,
  input  logic [rhcc_pkg::PIX_W-1:0]          green_i,
  input  logic [rhcc_pkg::PIX_W-1:0]          blue_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rhcc_pkg::HUE_OUT_W-1:0]      hue_angle_o,
  output logic [rhcc_pkg::CLASS_W-1:0]        color_class_o,
  output logic                                is_gray_o
);

  localparam int PW    = rhcc_pkg::PIX_W;
  localparam int KMUL  = rhcc_pkg::DEG_60 << FRAC_BITS;
  localparam int QW    = $clog2(KMUL + 1);
  localparam int NW    = PW + QW;
  localparam int HUE_W = $clog2(rhcc_pkg::DEG_360 << FRAC_BITS);

  localparam logic [NW-1:0]    K_N     = NW'(KMUL);
  localparam logic [HUE_W-1:0] HUE_30  = HUE_W'(rhcc_pkg::DEG_30 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_75  = HUE_W'(rhcc_pkg::DEG_75 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(rhcc_pkg::DEG_120 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_135 = HUE_W'(rhcc_pkg::DEG_135 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(rhcc_pkg::DEG_240 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_345 = HUE_W'(rhcc_pkg::DEG_345 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_360 = HUE_W'((rhcc_pkg::DEG_360 << FRAC_BITS) - 1) + 1'b1;

  // ---------------------------------------------------------------- ready chain
  logic              s1_rdy, s3_rdy, s4_rdy;
  logic [QW:0]       d_rdy;

  logic              s1_v_q, s3_v_q, s4_v_q;
  logic [QW:0]       d_v_q;

  always_comb begin
    s4_rdy = !s4_v_q || out_ready_i;
    s3_rdy = !s3_v_q || s4_rdy;
    d_rdy[QW] = !d_v_q[QW] || s3_rdy;
    for (int j = QW - 1; j >= 0; j--) begin
      d_rdy[j] = !d_v_q[j] || d_rdy[j+1];
    end
    s1_rdy = !s1_v_q || d_rdy[0];
  end

  assign in_ready_o = s1_rdy;

  // ---------------------------------------------------------------- stage 1
  logic [PW-1:0]       mx, mn;
  logic signed [PW:0]  diff;
  rhcc_pkg::sector_e   sec_d;

  logic [PW-1:0]       s1_mag_q, s1_delta_q;
  logic                s1_neg_q, s1_gray_q;
  rhcc_pkg::sector_e   s1_sec_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    priority if (mx == red_i) begin
      sec_d = rhcc_pkg::SEC_RED;
      diff  = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (mx == green_i) begin
      sec_d = rhcc_pkg::SEC_GREEN;
      diff  = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sec_d = rhcc_pkg::SEC_BLUE;
      diff  = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_mag_q   <= diff[PW] ? PW'(-diff) : diff[PW-1:0];
      s1_neg_q   <= diff[PW];
      s1_delta_q <= mx - mn;
      s1_gray_q  <= (mx == mn);
      s1_sec_q   <= sec_d;
    end
  end

  // ---------------------------------------------------------------- stage 2 and divider
  // Index 0 holds the product split into starting remainder and dividend low bits;
  // index j + 1 holds the state after quotient bit QW-1-j.
  logic [PW-1:0]       d_rem_q   [QW+1];
  logic [QW-1:0]       d_low_q   [QW+1];
  logic [QW-1:0]       d_quot_q  [QW+1];
  logic [PW-1:0]       d_delta_q [QW+1];
  logic                d_neg_q   [QW+1];
  logic                d_gray_q  [QW+1];
  rhcc_pkg::sector_e   d_sec_q   [QW+1];

  logic [NW-1:0]       prod;

  assign prod = NW'(s1_mag_q) * K_N;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q[0] <= 1'b0;
    end else if (d_rdy[0]) begin
      d_v_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy[0] && s1_v_q) begin
      d_rem_q[0]   <= prod[NW-1:QW];
      d_low_q[0]   <= prod[QW-1:0];
      d_quot_q[0]  <= '0;
      d_delta_q[0] <= s1_delta_q;
      d_neg_q[0]   <= s1_neg_q;
      d_gray_q[0]  <= s1_gray_q;
      d_sec_q[0]   <= s1_sec_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [PW:0]   trial;
    logic          take;
    logic [PW-1:0] rem_d;
    logic [QW-1:0] quot_d;

    always_comb begin
      trial  = {d_rem_q[j], d_low_q[j][QW-1-j]};
      take   = (trial >= {1'b0, d_delta_q[j]});
      rem_d  = take ? PW'(trial - {1'b0, d_delta_q[j]}) : trial[PW-1:0];
      quot_d = d_quot_q[j];
      quot_d[QW-1-j] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[j+1] <= 1'b0;
      end else if (d_rdy[j+1]) begin
        d_v_q[j+1] <= d_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (d_rdy[j+1] && d_v_q[j]) begin
        d_rem_q[j+1]   <= rem_d;
        d_low_q[j+1]   <= d_low_q[j];
        d_quot_q[j+1]  <= quot_d;
        d_delta_q[j+1] <= d_delta_q[j];
        d_neg_q[j+1]   <= d_neg_q[j];
        d_gray_q[j+1]  <= d_gray_q[j];
        d_sec_q[j+1]   <= d_sec_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: hue
  logic [HUE_W-1:0] quot_e, hue_d;
  logic [HUE_W-1:0] s3_hue_q;
  logic             s3_gray_q;

  assign quot_e = HUE_W'(d_quot_q[QW]);

  always_comb begin
    if (d_gray_q[QW]) begin
      hue_d = '0;
    end else begin
      unique case (d_sec_q[QW])
        rhcc_pkg::SEC_RED: begin
          hue_d = (d_neg_q[QW] && (quot_e != '0)) ? HUE_360 - quot_e : quot_e;
        end
        rhcc_pkg::SEC_GREEN: begin
          hue_d = d_neg_q[QW] ? HUE_120 - quot_e : HUE_120 + quot_e;
        end
        rhcc_pkg::SEC_BLUE: begin
          hue_d = d_neg_q[QW] ? HUE_240 - quot_e : HUE_240 + quot_e;
        end
        default: begin
          hue_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= d_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && d_v_q[QW]) begin
      s3_hue_q  <= hue_d;
      s3_gray_q <= d_gray_q[QW];
    end
  end

  // ---------------------------------------------------------------- stage 4: class
  rhcc_pkg::color_class_e cls_d, s4_cls_q;
  logic [rhcc_pkg::HUE_OUT_W-1:0] s4_hue_q;
  logic                           s4_gray_q;

  always_comb begin
    priority if (s3_hue_q < HUE_30 || s3_hue_q > HUE_345) begin
      cls_d = rhcc_pkg::CLS_RED;
    end else if (s3_hue_q > HUE_30 && s3_hue_q < HUE_75) begin
      cls_d = rhcc_pkg::CLS_YELLOW;
    end else if (s3_hue_q > HUE_75 && s3_hue_q < HUE_135) begin
      cls_d = rhcc_pkg::CLS_GREEN;
    end else begin
      cls_d = rhcc_pkg::CLS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_v_q) begin
      s4_hue_q  <= rhcc_pkg::HUE_OUT_W'(s3_hue_q);
      s4_cls_q  <= cls_d;
      s4_gray_q <= s3_gray_q;
    end
  end

  assign out_valid_o   = s4_v_q;
  assign hue_angle_o   = s4_hue_q;
  assign color_class_o = s4_cls_q;
  assign is_gray_o     = s4_gray_q;

`ifndef SYNTHESIS
  a_gray_hue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_gray_o |-> hue_angle_o == '0 && color_class_o == rhcc_pkg::CLS_RED)
    else $error("gray transaction with nonzero hue or non-red class");

  a_div_rem_below_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q[QW] && !d_gray_q[QW] |-> d_rem_q[QW] < d_delta_q[QW])
    else $error("divider remainder not below delta");

  a_hue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> s3_hue_q < HUE_360 || HUE_360 == '0)
    else $error("hue at or above 360 degrees");

  a_empty_output_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");
`endif

endmodule
